// File: hw/rtl/atrs_pkg.sv
// atrs_pkg: shared widths, codes and types for the AoA tone rate selector.
// No dependencies; imported by every module of the block.
`default_nettype none

package atrs_pkg;

    localparam int ANG_W      = 13;  // angle, 0.01 deg, signed
    localparam int IAS_W      = 13;  // airspeed, 0.1 kt
    localparam int LIM_W      = 9;   // mute airspeed limit, whole knots
    localparam int RATE_W     = 12;  // pulse rate, 0.01 pps
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;
    localparam int PROD_W     = ANG_W + RATE_W;  // band offset times rate span
    localparam int QDEPTH     = 2;

    typedef enum logic [1:0] {
        TONE_NONE = 2'd0,
        TONE_LOW  = 2'd1,
        TONE_HIGH = 2'd2
    } t_tone;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STALL = 3'd0,
        CFG_SLOW  = 3'd1,
        CFG_FAST  = 3'd2,
        CFG_GLIDE = 3'd3,
        CFG_MUTE  = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic signed [ANG_W-1:0] stall;
        logic signed [ANG_W-1:0] slow;
        logic signed [ANG_W-1:0] fast;
        logic signed [ANG_W-1:0] glide;
        logic [LIM_W-1:0]        mute;
    } t_cfg;

    // Classified request: rate = base +/- (num * dmag) / den
    typedef struct packed {
        t_tone             kind;
        logic [ANG_W-1:0]  num;
        logic [ANG_W-1:0]  den;
        logic [RATE_W-1:0] dmag;
        logic              dneg;
        logic [RATE_W-1:0] base;
    } t_job;

endpackage

`default_nettype wire

// File: hw/rtl/aoa_tone_rate_select_core.sv
// aoa_tone_rate_select_core: top level of the AoA tone rate selector.
// Depends on atrs_pkg, atrs_front, atrs_queue, atrs_back.
//
// Usage:
//  - Request channel: a request (angle sample, airspeed, mode flag) is taken
//    at a rising edge with start high and busy low. busy stays low in
//    operation, so one request per clock is sustained.
//  - Result channel: o_done is high for exactly one cycle with o_tone_kind
//    and o_pulse_rate valid. Results leave in request order, one per
//    request. The receiver cannot stall; none is needed since the back end
//    never stops.
//  - Pipeline: a request passes the front register, queue, multiply stage,
//    twelve divide stages and output register on its way to the result.
//    Throughput: 1 request per cycle, set by the fully pipelined divider
//    (one quotient bit per stage).
//  - Config: i_cfg_we writes register i_cfg_idx (0 stall, 1 slow edge,
//    2 fast edge, 3 best glide, 4 mute airspeed limit); other indexes are
//    dropped. Write only while no request is in flight.
//  - Reset (synchronous, active low): thresholds clear to zero, which reads
//    as uncalibrated (silent); all in-flight requests are dropped.
`default_nettype none

module aoa_tone_rate_select_core #(
    parameter int STALL_RATE    = 2000,
    parameter int HIGH_RATE_MIN = 150,
    parameter int HIGH_RATE_MAX = 620,
    parameter int LOW_RATE_MIN  = 150,
    parameter int LOW_RATE_MAX  = 820
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                start,
    output logic                               busy,
    input  wire [atrs_pkg::ANG_W-1:0]          i_angle_sample,
    input  wire [atrs_pkg::IAS_W-1:0]          i_airspeed,
    input  wire                                i_func,
    output logic                               o_done,
    output logic [1:0]                         o_tone_kind,
    output logic [atrs_pkg::RATE_W-1:0]        o_pulse_rate,
    input  wire                                i_cfg_we,
    input  wire [atrs_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire [atrs_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import atrs_pkg::*;

    t_cfg r_cfg;
    logic take;
    logic f_vld;
    t_job f_job;
    logic q_full;
    logic q_vld;
    t_job q_job;

    // threshold register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_STALL: r_cfg.stall <= i_cfg_data[ANG_W-1:0];
                CFG_SLOW:  r_cfg.slow  <= i_cfg_data[ANG_W-1:0];
                CFG_FAST:  r_cfg.fast  <= i_cfg_data[ANG_W-1:0];
                CFG_GLIDE: r_cfg.glide <= i_cfg_data[ANG_W-1:0];
                CFG_MUTE:  r_cfg.mute  <= i_cfg_data[LIM_W-1:0];
                default: ;
            endcase
        end
    end

    // back end pops every cycle, so the queue only fills if that changes
    assign busy = q_full;
    assign take = start && !busy;

    atrs_front #(
        .STALL_RATE    (STALL_RATE),
        .HIGH_RATE_MIN (HIGH_RATE_MIN),
        .HIGH_RATE_MAX (HIGH_RATE_MAX),
        .LOW_RATE_MIN  (LOW_RATE_MIN),
        .LOW_RATE_MAX  (LOW_RATE_MAX)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_take         (take),
        .i_angle_sample (i_angle_sample),
        .i_airspeed     (i_airspeed),
        .i_func         (i_func),
        .i_cfg          (r_cfg),
        .o_vld          (f_vld),
        .o_job          (f_job)
    );

    atrs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_vld),
        .i_job   (f_job),
        .i_pop   (q_vld),
        .o_full  (q_full),
        .o_vld   (q_vld),
        .o_job   (q_job)
    );

    atrs_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_vld        (q_vld),
        .i_job        (q_job),
        .o_done       (o_done),
        .o_tone_kind  (o_tone_kind),
        .o_pulse_rate (o_pulse_rate)
    );

endmodule

`default_nettype wire

// File: hw/rtl/atrs_front.sv
// atrs_front: accepts a request, picks the tone band and sets up the rate math.
// Depends on atrs_pkg.
`default_nettype none

module atrs_front #(
    parameter int STALL_RATE    = 2000,
    parameter int HIGH_RATE_MIN = 150,
    parameter int HIGH_RATE_MAX = 620,
    parameter int LOW_RATE_MIN  = 150,
    parameter int LOW_RATE_MAX  = 820
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_take,
    input  wire [atrs_pkg::ANG_W-1:0]      i_angle_sample,
    input  wire [atrs_pkg::IAS_W-1:0]      i_airspeed,
    input  wire                            i_func,
    input  atrs_pkg::t_cfg                 i_cfg,
    output logic                           o_vld,
    output atrs_pkg::t_job                 o_job
);
    import atrs_pkg::*;

    localparam int HIGH_DIFF = HIGH_RATE_MAX - HIGH_RATE_MIN;
    localparam int LOW_DIFF  = LOW_RATE_MAX - LOW_RATE_MIN;
    localparam logic HIGH_NEG = (HIGH_DIFF < 0);
    localparam logic LOW_NEG  = (LOW_DIFF < 0);
    localparam logic [RATE_W-1:0] HIGH_MAG = RATE_W'(HIGH_NEG ? -HIGH_DIFF : HIGH_DIFF);
    localparam logic [RATE_W-1:0] LOW_MAG  = RATE_W'(LOW_NEG ? -LOW_DIFF : LOW_DIFF);

    // x - y where x >= y is known; fits ANG_W bits unsigned
    function automatic logic [ANG_W-1:0] adiff(input logic signed [ANG_W-1:0] x,
                                               input logic signed [ANG_W-1:0] y);
        logic [ANG_W:0] t;
        t = {x[ANG_W-1], x} - {y[ANG_W-1], y};
        return t[ANG_W-1:0];
    endfunction

    logic signed [ANG_W-1:0] a;
    logic [IAS_W-1:0]        lim10;
    t_job                    n_job;
    logic                    r_vld;
    t_job                    r_job;

    assign a     = $signed(i_angle_sample);
    assign lim10 = IAS_W'({i_cfg.mute, 3'b000}) + IAS_W'({i_cfg.mute, 1'b0});

    always_comb begin
        n_job      = '0;
        n_job.kind = TONE_NONE;
        n_job.den  = ANG_W'(1);
        if (i_cfg.stall[ANG_W-1] || (i_cfg.stall == '0)) begin
            // uncalibrated: silent
        end else if (i_func) begin
            if ((a >= i_cfg.stall) && (i_airspeed > lim10)) begin
                n_job.kind = TONE_HIGH;
                n_job.base = RATE_W'(STALL_RATE);
            end
        end else if (a >= i_cfg.stall) begin
            n_job.kind = TONE_HIGH;
            n_job.base = RATE_W'(STALL_RATE);
        end else if (a > i_cfg.slow) begin
            n_job.kind = TONE_HIGH;
            n_job.num  = adiff(a, i_cfg.slow);
            n_job.den  = adiff(i_cfg.stall, i_cfg.slow);
            n_job.dmag = HIGH_MAG;
            n_job.dneg = HIGH_NEG;
            n_job.base = RATE_W'(HIGH_RATE_MIN);
        end else if (a >= i_cfg.fast) begin
            n_job.kind = TONE_LOW;
        end else if ((a >= i_cfg.glide) && (i_cfg.glide < i_cfg.fast)) begin
            n_job.kind = TONE_LOW;
            n_job.num  = adiff(a, i_cfg.glide);
            n_job.den  = adiff(i_cfg.fast, i_cfg.glide);
            n_job.dmag = LOW_MAG;
            n_job.dneg = LOW_NEG;
            n_job.base = RATE_W'(LOW_RATE_MIN);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_job <= n_job;
        end
    end

    assign o_vld = r_vld;
    assign o_job = r_job;

endmodule

`default_nettype wire

// File: hw/rtl/atrs_queue.sv
// atrs_queue: short FIFO of classified requests between front and back.
// Depends on atrs_pkg.
`default_nettype none

module atrs_queue (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_push,
    input  atrs_pkg::t_job  i_job,
    input  wire             i_pop,
    output logic            o_full,
    output logic            o_vld,
    output atrs_pkg::t_job  o_job
);
    import atrs_pkg::*;

    localparam int QAW = $clog2(QDEPTH);
    localparam int QCW = $clog2(QDEPTH + 1);

    t_job           r_mem [QDEPTH];
    logic [QAW-1:0] r_wr_ptr;
    logic [QAW-1:0] r_rd_ptr;
    logic [QCW-1:0] r_cnt;
    logic           do_push;
    logic           do_pop;

    assign o_full  = (r_cnt == QCW'(QDEPTH));
    assign o_vld   = (r_cnt != '0);
    assign do_pop  = i_pop && o_vld;
    assign do_push = i_push && (!o_full || do_pop);
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == QAW'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QAW'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/atrs_back.sv
// atrs_back: multiply, pipelined restoring divide (one quotient bit per stage)
// and rate assembly. Depends on atrs_pkg.
`default_nettype none

module atrs_back (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_vld,
    input  atrs_pkg::t_job                 i_job,
    output logic                           o_done,
    output logic [1:0]                     o_tone_kind,
    output logic [atrs_pkg::RATE_W-1:0]    o_pulse_rate
);
    import atrs_pkg::*;

    // quotient < dmag <= 12 bits since num < den
    localparam int NST = RATE_W;

    logic [PROD_W-1:0] r_rem  [NST];
    logic [ANG_W-1:0]  r_den  [NST];
    logic [RATE_W-1:0] r_q    [NST+1];
    logic [RATE_W-1:0] r_base [NST+1];
    logic              r_neg  [NST+1];
    t_tone             r_kind [NST+1];
    logic              r_vld  [NST+1];

    logic [PROD_W-1:0] sh    [NST];
    logic              ge    [NST];
    logic [PROD_W-1:0] n_rem [NST];

    logic              r_done;
    t_tone             r_kind_o;
    logic [RATE_W-1:0] r_rate_o;
    logic [RATE_W-1:0] n_rate;

    always_comb begin
        for (int k = 0; k < NST; k++) begin
            sh[k]    = PROD_W'(r_den[k]) << (NST - 1 - k);
            ge[k]    = (r_rem[k] >= sh[k]);
            n_rem[k] = ge[k] ? (r_rem[k] - sh[k]) : r_rem[k];
        end
    end

    assign n_rate = r_neg[NST] ? (r_base[NST] - r_q[NST]) : (r_base[NST] + r_q[NST]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= NST; k++) begin
                r_vld[k] <= 1'b0;
            end
            r_done <= 1'b0;
        end else begin
            r_vld[0] <= i_vld;
            for (int k = 0; k < NST; k++) begin
                r_vld[k+1] <= r_vld[k];
            end
            r_done <= r_vld[NST];
        end
    end

    always_ff @(posedge i_clk) begin
        // stage 0: product of band offset and rate span
        r_rem[0]  <= PROD_W'(i_job.num) * PROD_W'(i_job.dmag);
        r_den[0]  <= i_job.den;
        r_q[0]    <= '0;
        r_base[0] <= i_job.base;
        r_neg[0]  <= i_job.dneg;
        r_kind[0] <= i_job.kind;
        for (int k = 0; k < NST; k++) begin
            if (k + 1 < NST) begin
                r_rem[k+1] <= n_rem[k];
                r_den[k+1] <= r_den[k];
            end
            r_q[k+1]    <= {r_q[k][RATE_W-2:0], ge[k]};
            r_base[k+1] <= r_base[k];
            r_neg[k+1]  <= r_neg[k];
            r_kind[k+1] <= r_kind[k];
        end
        r_kind_o <= r_kind[NST];
        r_rate_o <= n_rate;
    end

    assign o_done       = r_done;
    assign o_tone_kind  = r_kind_o;
    assign o_pulse_rate = r_rate_o;

endmodule

`default_nettype wire
